### hw/rtl/dnsp_pkg.sv
package dnsp_pkg;

	// Depth of the event queue between the parser and the output side
	localparam int DNSP_QUEUE_DEPTH = 4;

	localparam int KIND_W = 5;
	localparam int VALUE_W = 32;
	localparam int SEC_W = 3;

	// Event kinds
	localparam logic [KIND_W-1:0] EV_ID         = 5'd0;
	localparam logic [KIND_W-1:0] EV_FLAGS      = 5'd1;
	localparam logic [KIND_W-1:0] EV_QDCOUNT    = 5'd2;
	localparam logic [KIND_W-1:0] EV_ANCOUNT    = 5'd3;
	localparam logic [KIND_W-1:0] EV_NSCOUNT    = 5'd4;
	localparam logic [KIND_W-1:0] EV_ARCOUNT    = 5'd5;
	localparam logic [KIND_W-1:0] EV_LABEL_LEN  = 5'd6;
	localparam logic [KIND_W-1:0] EV_LABEL_BYTE = 5'd7;
	localparam logic [KIND_W-1:0] EV_NAME_END   = 5'd8;
	localparam logic [KIND_W-1:0] EV_POINTER    = 5'd9;
	localparam logic [KIND_W-1:0] EV_QTYPE      = 5'd10;
	localparam logic [KIND_W-1:0] EV_QCLASS     = 5'd11;
	localparam logic [KIND_W-1:0] EV_TYPE       = 5'd12;
	localparam logic [KIND_W-1:0] EV_CLASS      = 5'd13;
	localparam logic [KIND_W-1:0] EV_TTL        = 5'd14;
	localparam logic [KIND_W-1:0] EV_RDLENGTH   = 5'd15;
	localparam logic [KIND_W-1:0] EV_RDATA_BYTE = 5'd16;
	localparam logic [KIND_W-1:0] EV_ERROR      = 5'd17;

	// Sections
	localparam logic [SEC_W-1:0] SEC_HEADER     = 3'd0;
	localparam logic [SEC_W-1:0] SEC_QUESTION   = 3'd1;
	localparam logic [SEC_W-1:0] SEC_ANSWER     = 3'd2;
	localparam logic [SEC_W-1:0] SEC_AUTHORITY  = 3'd3;
	localparam logic [SEC_W-1:0] SEC_ADDITIONAL = 3'd4;

	// Header word indexes that load the record counts
	localparam logic [2:0] HDR_QDCOUNT = 3'd2;
	localparam logic [2:0] HDR_ANCOUNT = 3'd3;
	localparam logic [2:0] HDR_NSCOUNT = 3'd4;
	localparam logic [2:0] HDR_ARCOUNT = 3'd5;

	// Name byte label types (top two bits)
	localparam logic [1:0] LT_LABEL   = 2'b00;
	localparam logic [1:0] LT_POINTER = 2'b11;

	typedef enum logic [3:0] {
		PH_IDLE,
		PH_HDR,
		PH_NAME,
		PH_LABEL,
		PH_PTRLO,
		PH_QTYPE,
		PH_QCLASS,
		PH_TYPE,
		PH_CLASS,
		PH_TTL,
		PH_RDLEN,
		PH_RDATA,
		PH_DONE,
		PH_ERROR
	} phase_t;

	typedef struct packed {
		logic [KIND_W-1:0]  kind;
		logic [VALUE_W-1:0] value;
		logic [SEC_W-1:0]   section;
		logic               last;
	} evt_t;

endpackage

### hw/rtl/dnsp_parser.sv
module dnsp_parser (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          accept,
	input  logic [7:0]    data_byte,
	input  logic          message_start,
	output logic          evt_valid,
	output dnsp_pkg::evt_t evt
);
	import dnsp_pkg::*;

	phase_t      phase_q, phase_nxt, eff_phase;
	logic [2:0]  word_q, word_nxt, eff_word;
	logic [1:0]  bcnt_q, bcnt_nxt, eff_bcnt;
	logic [31:0] acc_q, acc_new;
	logic [15:0] qd_q, an_q, ns_q, ar_q;
	logic [15:0] qd_nxt, an_nxt, ns_nxt, ar_nxt;
	logic [15:0] eff_qd, eff_an, eff_ns, eff_ar;
	logic [15:0] rec_qd, rec_an, rec_ns, rec_ar;
	logic [5:0]  label_q, label_nxt, label_dec;
	logic [15:0] rdata_q, rdata_nxt, rdata_dec;
	logic [5:0]  ptr_hi_q, ptr_hi_nxt;
	logic [2:0]  bcnt_inc;
	logic        fld_done, rec_done;
	logic [15:0] v16;
	logic [SEC_W-1:0] cur_sec;
	phase_t      after_name;

	// A message start discards whatever is in progress
	assign eff_phase = message_start ? PH_HDR : phase_q;
	assign eff_word  = message_start ? 3'd0 : word_q;
	assign eff_bcnt  = message_start ? 2'd0 : bcnt_q;
	assign eff_qd    = message_start ? 16'd0 : qd_q;
	assign eff_an    = message_start ? 16'd0 : an_q;
	assign eff_ns    = message_start ? 16'd0 : ns_q;
	assign eff_ar    = message_start ? 16'd0 : ar_q;

	assign acc_new  = {acc_q[23:0], data_byte};
	assign v16      = acc_new[15:0];
	assign bcnt_inc = {1'b0, eff_bcnt} + 3'd1;
	assign fld_done = (eff_phase == PH_TTL) ? (bcnt_inc == 3'd4) : (bcnt_inc >= 3'd2);

	assign label_dec = (label_q != 6'd0) ? label_q - 6'd1 : 6'd0;
	assign rdata_dec = (rdata_q != 16'd0) ? rdata_q - 16'd1 : 16'd0;

	always_comb begin
		if (eff_qd != 16'd0) cur_sec = SEC_QUESTION;
		else if (eff_an != 16'd0) cur_sec = SEC_ANSWER;
		else if (eff_ns != 16'd0) cur_sec = SEC_AUTHORITY;
		else cur_sec = SEC_ADDITIONAL;
	end

	assign after_name = (eff_qd != 16'd0) ? PH_QTYPE : PH_TYPE;

	// Counts after closing one record
	always_comb begin
		rec_qd = eff_qd;
		rec_an = eff_an;
		rec_ns = eff_ns;
		rec_ar = eff_ar;
		if (eff_qd != 16'd0) rec_qd = eff_qd - 16'd1;
		else if (eff_an != 16'd0) rec_an = eff_an - 16'd1;
		else if (eff_ns != 16'd0) rec_ns = eff_ns - 16'd1;
		else if (eff_ar != 16'd0) rec_ar = eff_ar - 16'd1;
	end
	assign rec_done = (rec_qd | rec_an | rec_ns | rec_ar) == 16'd0;

	// Next state
	always_comb begin
		phase_nxt  = eff_phase;
		word_nxt   = eff_word;
		bcnt_nxt   = eff_bcnt;
		qd_nxt     = eff_qd;
		an_nxt     = eff_an;
		ns_nxt     = eff_ns;
		ar_nxt     = eff_ar;
		label_nxt  = label_q;
		rdata_nxt  = rdata_q;
		ptr_hi_nxt = ptr_hi_q;

		unique case (eff_phase)
			PH_HDR, PH_QTYPE, PH_QCLASS, PH_TYPE, PH_CLASS, PH_TTL, PH_RDLEN: begin
				bcnt_nxt = fld_done ? 2'd0 : bcnt_inc[1:0];
			end
			default: ;
		endcase

		unique case (eff_phase)
			PH_HDR: begin
				if (fld_done) begin
					unique case (eff_word)
						HDR_QDCOUNT: qd_nxt = v16;
						HDR_ANCOUNT: an_nxt = v16;
						HDR_NSCOUNT: ns_nxt = v16;
						HDR_ARCOUNT: ar_nxt = v16;
						default: ;
					endcase
					if (eff_word != HDR_ARCOUNT) word_nxt = eff_word + 3'd1;
					else if ((eff_qd | eff_an | eff_ns | v16) == 16'd0) phase_nxt = PH_DONE;
					else phase_nxt = PH_NAME;
				end
			end
			PH_NAME: begin
				unique case (data_byte[7:6])
					LT_POINTER: begin
						ptr_hi_nxt = data_byte[5:0];
						phase_nxt  = PH_PTRLO;
					end
					LT_LABEL: begin
						if (data_byte == 8'h00) phase_nxt = after_name;
						else begin
							label_nxt = data_byte[5:0];
							phase_nxt = PH_LABEL;
						end
					end
					default: phase_nxt = PH_ERROR;
				endcase
			end
			PH_LABEL: begin
				label_nxt = label_dec;
				if (label_dec == 6'd0) phase_nxt = PH_NAME;
			end
			PH_PTRLO: phase_nxt = after_name;
			PH_QTYPE: if (fld_done) phase_nxt = PH_QCLASS;
			PH_QCLASS: begin
				if (fld_done) begin
					qd_nxt = rec_qd; an_nxt = rec_an; ns_nxt = rec_ns; ar_nxt = rec_ar;
					phase_nxt = rec_done ? PH_DONE : PH_NAME;
				end
			end
			PH_TYPE:  if (fld_done) phase_nxt = PH_CLASS;
			PH_CLASS: if (fld_done) phase_nxt = PH_TTL;
			PH_TTL:   if (fld_done) phase_nxt = PH_RDLEN;
			PH_RDLEN: begin
				if (fld_done) begin
					rdata_nxt = v16;
					if (v16 == 16'd0) begin
						qd_nxt = rec_qd; an_nxt = rec_an; ns_nxt = rec_ns; ar_nxt = rec_ar;
						phase_nxt = rec_done ? PH_DONE : PH_NAME;
					end else phase_nxt = PH_RDATA;
				end
			end
			PH_RDATA: begin
				rdata_nxt = rdata_dec;
				if (rdata_dec == 16'd0) begin
					qd_nxt = rec_qd; an_nxt = rec_an; ns_nxt = rec_ns; ar_nxt = rec_ar;
					phase_nxt = rec_done ? PH_DONE : PH_NAME;
				end
			end
			default: ;
		endcase
	end

	// Event outputs
	always_comb begin
		evt_valid   = 1'b0;
		evt.kind    = EV_ID;
		evt.value   = {24'd0, data_byte};
		evt.section = cur_sec;
		evt.last    = 1'b0;

		unique case (eff_phase)
			PH_HDR: begin
				evt_valid   = fld_done;
				evt.kind    = EV_ID + {2'd0, eff_word};
				evt.value   = {16'd0, v16};
				evt.section = SEC_HEADER;
				evt.last    = (eff_word == HDR_ARCOUNT) &&
				              ((eff_qd | eff_an | eff_ns | v16) == 16'd0);
			end
			PH_NAME: begin
				unique case (data_byte[7:6])
					LT_POINTER: evt_valid = 1'b0;
					LT_LABEL: begin
						evt_valid = 1'b1;
						if (data_byte == 8'h00) begin
							evt.kind  = EV_NAME_END;
							evt.value = 32'd0;
						end else evt.kind = EV_LABEL_LEN;
					end
					default: begin
						evt_valid = 1'b1;
						evt.kind  = EV_ERROR;
						evt.last  = 1'b1;
					end
				endcase
			end
			PH_LABEL: begin
				evt_valid = 1'b1;
				evt.kind  = EV_LABEL_BYTE;
			end
			PH_PTRLO: begin
				evt_valid = 1'b1;
				evt.kind  = EV_POINTER;
				evt.value = {18'd0, ptr_hi_q, data_byte};
			end
			PH_QTYPE: begin
				evt_valid   = fld_done;
				evt.kind    = EV_QTYPE;
				evt.value   = {16'd0, v16};
				evt.section = SEC_QUESTION;
			end
			PH_QCLASS: begin
				evt_valid   = fld_done;
				evt.kind    = EV_QCLASS;
				evt.value   = {16'd0, v16};
				evt.section = SEC_QUESTION;
				evt.last    = rec_done;
			end
			PH_TYPE: begin
				evt_valid = fld_done;
				evt.kind  = EV_TYPE;
				evt.value = {16'd0, v16};
			end
			PH_CLASS: begin
				evt_valid = fld_done;
				evt.kind  = EV_CLASS;
				evt.value = {16'd0, v16};
			end
			PH_TTL: begin
				evt_valid = fld_done;
				evt.kind  = EV_TTL;
				evt.value = acc_new;
			end
			PH_RDLEN: begin
				evt_valid = fld_done;
				evt.kind  = EV_RDLENGTH;
				evt.value = {16'd0, v16};
				evt.last  = (v16 == 16'd0) && rec_done;
			end
			PH_RDATA: begin
				evt_valid = 1'b1;
				evt.kind  = EV_RDATA_BYTE;
				evt.last  = (rdata_dec == 16'd0) && rec_done;
			end
			default: evt_valid = 1'b0;
		endcase

		if (!accept) evt_valid = 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			word_q   <= 3'd0;
			bcnt_q   <= 2'd0;
			qd_q     <= 16'd0;
			an_q     <= 16'd0;
			ns_q     <= 16'd0;
			ar_q     <= 16'd0;
			label_q  <= 6'd0;
			rdata_q  <= 16'd0;
			ptr_hi_q <= 6'd0;
		end else if (accept) begin
			phase_q  <= phase_nxt;
			word_q   <= word_nxt;
			bcnt_q   <= bcnt_nxt;
			qd_q     <= qd_nxt;
			an_q     <= an_nxt;
			ns_q     <= ns_nxt;
			ar_q     <= ar_nxt;
			label_q  <= label_nxt;
			rdata_q  <= rdata_nxt;
			ptr_hi_q <= ptr_hi_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) acc_q <= acc_new;
	end

endmodule

### hw/rtl/dnsp_queue.sv
module dnsp_queue #(
	parameter int DEPTH = dnsp_pkg::DNSP_QUEUE_DEPTH
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  dnsp_pkg::evt_t push_evt,
	output logic           full,
	input  logic           pop,
	output logic           not_empty,
	output dnsp_pkg::evt_t head
);
	import dnsp_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	evt_t             slots_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push, do_pop;

	assign full      = (count_q == CNT_FULL);
	assign not_empty = (count_q != '0);
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;
	assign head      = slots_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) slots_q[wr_ptr_q] <= push_evt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PTR_W'(1);
			if (do_pop)  rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PTR_W'(1);
			if (do_push && !do_pop) count_q <= count_q + CNT_W'(1);
			else if (do_pop && !do_push) count_q <= count_q - CNT_W'(1);
		end
	end

endmodule

### hw/rtl/dns_response_parser.sv
// Channel  Handshake              Payload
// in       in_valid / in_stall    data_byte[7:0], message_start
// out      out_valid / out_stall  event_kind[4:0], event_value[31:0], section[2:0], last_event
//
// One byte is taken every cycle while the event queue has room; the per-byte parser
// update is combinational, so each byte pushes at most one event into the queue.
// in_stall rises only when the QUEUE_DEPTH-entry event queue is full, i.e. when the
// consumer has held out_stall long enough to back it up.
// Reset (arst_n low) returns the parser to idle and empties the queue; bytes seen
// before the first message_start produce no event.
module dns_response_parser #(
	parameter int QUEUE_DEPTH = dnsp_pkg::DNSP_QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        message_start,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [4:0]  event_kind,
	output logic [31:0] event_value,
	output logic [2:0]  section,
	output logic        last_event
);
	import dnsp_pkg::*;

	logic accept;
	logic evt_valid;
	evt_t evt;
	logic q_full;
	logic q_pop;
	evt_t q_head;

	// Front: byte parser. A beat is taken whenever the queue is not full.
	assign in_stall = q_full;
	assign accept   = in_valid && !in_stall;

	dnsp_parser u_parser (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.data_byte    (data_byte),
		.message_start(message_start),
		.evt_valid    (evt_valid),
		.evt          (evt)
	);

	// Back: event queue, its head is the output beat and holds while stalled
	assign q_pop = out_valid && !out_stall;

	dnsp_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (evt_valid),
		.push_evt (evt),
		.full     (q_full),
		.pop      (q_pop),
		.not_empty(out_valid),
		.head     (q_head)
	);

	assign event_kind  = q_head.kind;
	assign event_value = q_head.value;
	assign section     = q_head.section;
	assign last_event  = q_head.last;

endmodule

### sim/dns_event_checker.sv
`timescale 1ns / 100ps

// Watches both channels of the parser, predicts the event stream byte by byte
// and compares each event taken from the block with the oldest prediction.
module dns_event_checker
	import dnsp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        message_start,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [4:0]  event_kind,
	input  logic [31:0] event_value,
	input  logic [2:0]  section,
	input  logic        last_event,
	output int          error_count,
	output int          events_owed
);

	localparam logic [KIND_W-1:0] HEADER_KINDS [0:5] = '{
		EV_ID, EV_FLAGS, EV_QDCOUNT, EV_ANCOUNT, EV_NSCOUNT, EV_ARCOUNT
	};

	// predictor state
	phase_t      phase = PH_IDLE;
	logic [2:0]  hdr_word = '0;
	logic [1:0]  fcount = '0;
	logic [31:0] acc = '0;
	logic [15:0] qd_left = '0, an_left = '0, ns_left = '0, ar_left = '0;
	logic [5:0]  lbl_left = '0;
	logic [15:0] rd_left = '0;
	logic [5:0]  ptr_hi = '0;

	evt_t expected_events[$];
	evt_t seen_ev, want_ev, new_ev;

	function automatic void clear_parser();
		phase = PH_IDLE;
		hdr_word = '0;
		fcount = '0;
		acc = '0;
		qd_left = '0;
		an_left = '0;
		ns_left = '0;
		ar_left = '0;
		lbl_left = '0;
		rd_left = '0;
		ptr_hi = '0;
	endfunction

	function automatic evt_t make_event(input logic [KIND_W-1:0] k, input logic [31:0] v,
			input logic [SEC_W-1:0] s, input logic l);
		evt_t e;
		e.kind = k;
		e.value = v;
		e.section = s;
		e.last = l;
		return e;
	endfunction

	function automatic logic counts_clear();
		return (qd_left | an_left | ns_left | ar_left) == 16'h0;
	endfunction

	function automatic logic [SEC_W-1:0] section_now();
		if (qd_left != 0) return SEC_QUESTION;
		if (an_left != 0) return SEC_ANSWER;
		if (ns_left != 0) return SEC_AUTHORITY;
		return SEC_ADDITIONAL;
	endfunction

	function automatic phase_t name_done_phase();
		return (qd_left != 0) ? PH_QTYPE : PH_TYPE;
	endfunction

	// big-endian field assembly; true once len bytes are in
	function automatic bit take_field_byte(input logic [7:0] b, input int len);
		acc = {acc[23:0], b};
		if (int'(fcount) + 1 >= len) begin
			fcount = '0;
			return 1'b1;
		end
		fcount = fcount + 2'd1;
		return 1'b0;
	endfunction

	// retires one record, returns the final-event flag
	function automatic logic close_record();
		if (qd_left != 0) qd_left--;
		else if (an_left != 0) an_left--;
		else if (ns_left != 0) ns_left--;
		else if (ar_left != 0) ar_left--;
		if (counts_clear()) begin
			phase = PH_DONE;
			return 1'b1;
		end
		phase = PH_NAME;
		return 1'b0;
	endfunction

	function automatic bit parse_byte(input logic [7:0] b, input logic start, output evt_t ev);
		logic [SEC_W-1:0] sec;
		logic [15:0]      w16;
		logic             fin;
		ev = '0;
		if (start) begin
			clear_parser();
			phase = PH_HDR;
		end
		sec = section_now();
		case (phase)
			PH_HDR: begin
				if (!take_field_byte(b, 2)) return 1'b0;
				w16 = acc[15:0];
				case (hdr_word)
					HDR_QDCOUNT: qd_left = w16;
					HDR_ANCOUNT: an_left = w16;
					HDR_NSCOUNT: ns_left = w16;
					HDR_ARCOUNT: ar_left = w16;
					default: ;
				endcase
				fin = 1'b0;
				if (hdr_word != HDR_ARCOUNT) hdr_word++;
				else if (counts_clear()) begin
					phase = PH_DONE;
					fin = 1'b1;
				end else phase = PH_NAME;
				ev = make_event(HEADER_KINDS[hdr_word - ((fin || phase == PH_NAME) ? 3'd0 : 3'd1)],
					{16'h0, w16}, SEC_HEADER, fin);
				return 1'b1;
			end
			PH_NAME: begin
				if (b[7:6] == LT_POINTER) begin
					ptr_hi = b[5:0];
					phase = PH_PTRLO;
					return 1'b0;
				end
				if (b[7:6] == LT_LABEL) begin
					if (b == 8'h00) begin
						phase = name_done_phase();
						ev = make_event(EV_NAME_END, 32'h0, sec, 1'b0);
					end else begin
						lbl_left = b[5:0];
						phase = PH_LABEL;
						ev = make_event(EV_LABEL_LEN, {24'h0, b}, sec, 1'b0);
					end
					return 1'b1;
				end
				// reserved label types: sticky until the next start
				phase = PH_ERROR;
				ev = make_event(EV_ERROR, {24'h0, b}, sec, 1'b1);
				return 1'b1;
			end
			PH_LABEL: begin
				if (lbl_left != 0) lbl_left--;
				if (lbl_left == 0) phase = PH_NAME;
				ev = make_event(EV_LABEL_BYTE, {24'h0, b}, sec, 1'b0);
				return 1'b1;
			end
			PH_PTRLO: begin
				phase = name_done_phase();
				ev = make_event(EV_POINTER, {18'h0, ptr_hi, b}, sec, 1'b0);
				return 1'b1;
			end
			PH_QTYPE: begin
				if (!take_field_byte(b, 2)) return 1'b0;
				phase = PH_QCLASS;
				ev = make_event(EV_QTYPE, {16'h0, acc[15:0]}, SEC_QUESTION, 1'b0);
				return 1'b1;
			end
			PH_QCLASS: begin
				if (!take_field_byte(b, 2)) return 1'b0;
				w16 = acc[15:0];
				fin = close_record();
				ev = make_event(EV_QCLASS, {16'h0, w16}, SEC_QUESTION, fin);
				return 1'b1;
			end
			PH_TYPE: begin
				if (!take_field_byte(b, 2)) return 1'b0;
				phase = PH_CLASS;
				ev = make_event(EV_TYPE, {16'h0, acc[15:0]}, sec, 1'b0);
				return 1'b1;
			end
			PH_CLASS: begin
				if (!take_field_byte(b, 2)) return 1'b0;
				phase = PH_TTL;
				ev = make_event(EV_CLASS, {16'h0, acc[15:0]}, sec, 1'b0);
				return 1'b1;
			end
			PH_TTL: begin
				if (!take_field_byte(b, 4)) return 1'b0;
				phase = PH_RDLEN;
				ev = make_event(EV_TTL, acc, sec, 1'b0);
				return 1'b1;
			end
			PH_RDLEN: begin
				if (!take_field_byte(b, 2)) return 1'b0;
				w16 = acc[15:0];
				rd_left = w16;
				fin = 1'b0;
				if (w16 == 16'h0) fin = close_record();
				else phase = PH_RDATA;
				ev = make_event(EV_RDLENGTH, {16'h0, w16}, sec, fin);
				return 1'b1;
			end
			PH_RDATA: begin
				if (rd_left != 0) rd_left--;
				fin = (rd_left == 0) ? close_record() : 1'b0;
				ev = make_event(EV_RDATA_BYTE, {24'h0, b}, sec, fin);
				return 1'b1;
			end
			default: return 1'b0;
		endcase
	endfunction

	function automatic void note_mismatch(input string what, input logic [31:0] want,
			input logic [31:0] got);
		error_count++;
		if (error_count <= 50)
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_parser();
			expected_events.delete();
			events_owed = 0;
		end else begin
			// output side first: an event can never stem from the byte taken on this edge
			if (out_valid && !out_stall) begin
				seen_ev = make_event(event_kind, event_value, section, last_event);
				if (expected_events.size() == 0) begin
					error_count++;
					if (error_count <= 50)
						$display("%0t: unexpected event, expected none, got kind %0d value %0h",
							$time, seen_ev.kind, seen_ev.value);
				end else begin
					want_ev = expected_events.pop_front();
					if (seen_ev.kind !== want_ev.kind)
						note_mismatch("event_kind", 32'(want_ev.kind), 32'(seen_ev.kind));
					if (seen_ev.value !== want_ev.value)
						note_mismatch("event_value", want_ev.value, seen_ev.value);
					if (seen_ev.section !== want_ev.section)
						note_mismatch("section", 32'(want_ev.section), 32'(seen_ev.section));
					if (seen_ev.last !== want_ev.last)
						note_mismatch("last_event", 32'(want_ev.last), 32'(seen_ev.last));
				end
			end
			if (in_valid && !in_stall) begin
				if (parse_byte(data_byte, message_start, new_ev))
					expected_events.push_back(new_ev);
			end
			events_owed = expected_events.size();
		end
	end

endmodule

### sim/testbench.sv
`timescale 1ns / 100ps

// Byte-stream stimulus for the DNS response parser. Directed beats first
// (stray bytes, empty message, restart mid-message, bad label type, zero
// rdlength, highest pointer), then randomly built messages: mostly well
// formed, with truncated, corrupted, padded and pure noise ones mixed in.
// The checker beside the block does all of the prediction and comparison.
module testbench;

	localparam int ITEM_TARGET = 1750;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic [7:0]  data_byte = 8'h00;
	logic        message_start = 1'b0;
	logic        out_stall = 1'b0;
	logic        in_stall;
	logic        out_valid;
	logic [4:0]  event_kind;
	logic [31:0] event_value;
	logic [2:0]  section;
	logic        last_event;

	int error_count;
	int events_owed;

	// sender/receiver idling controls
	bit no_idle = 1'b0;
	bit long_hold_req = 1'b0;
	int gap_odds = 0;
	int bytes_fed = 0;

	logic [7:0] msg_bytes[$];

	dns_response_parser dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.data_byte    (data_byte),
		.message_start(message_start),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.event_kind   (event_kind),
		.event_value  (event_value),
		.section      (section),
		.last_event   (last_event)
	);

	dns_event_checker chk (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.data_byte    (data_byte),
		.message_start(message_start),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.event_kind   (event_kind),
		.event_value  (event_value),
		.section      (section),
		.last_event   (last_event),
		.error_count  (error_count),
		.events_owed  (events_owed)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Hard stop. Slowest honest run is well under a tenth of this.
	initial begin
		#5ms;
		$display("RESULT: ERROR");
		$finish;
	end

	// Receiver: random stall bursts, quiet stretches, and one long hold-off
	// on request so that the event queue backs up and in_stall rises.
	initial begin
		forever begin
			@(posedge clk);
			if (long_hold_req) begin
				out_stall <= 1'b1;
				repeat (300) @(posedge clk);
				out_stall <= 1'b0;
				long_hold_req = 1'b0;
			end else if (!no_idle && $urandom_range(0, 5) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 17)) @(posedge clk);
				out_stall <= 1'b0;
			end else if ($urandom_range(0, 40) == 0) begin
				repeat ($urandom_range(30, 80)) @(posedge clk);
			end
		end
	end

	// One beat on the input channel; payload holds while stalled. Any gap
	// is decided only after acceptance, so valid never follows stall.
	task automatic send_byte(input logic [7:0] b, input logic s);
		in_valid <= 1'b1;
		data_byte <= b;
		message_start <= s;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		if (!no_idle && $urandom_range(1, 16) <= gap_odds) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
	endtask

	// whole message from the byte queue, start flag on the first beat
	task automatic send_message(input bit counted);
		foreach (msg_bytes[i]) begin
			send_byte(msg_bytes[i], i == 0);
			if (counted) bytes_fed++;
		end
	endtask

	// stray bytes after the message has closed or errored - the parser drops them
	task automatic send_junk(input int n);
		repeat (n) send_byte(8'($urandom_range(0, 255)), 1'b0);
	endtask

	// sender stands still until every predicted event has come out
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		wait (events_owed == 0);
	endtask

	task automatic push_word(input logic [15:0] w);
		msg_bytes.push_back(w[15:8]);
		msg_bytes.push_back(w[7:0]);
	endtask

	// Labels, then a root byte or a compression pointer; a corrupted name
	// ends on a reserved label type (top bits 01 or 10) instead.
	task automatic push_name(input bit corrupt);
		int         n_labels;
		int         len;
		logic [1:0] bad_type;
		n_labels = $urandom_range(0, 2);
		repeat (n_labels) begin
			len = ($urandom_range(0, 15) == 0) ? $urandom_range(7, 63) : $urandom_range(1, 4);
			msg_bytes.push_back(8'(len));
			repeat (len) msg_bytes.push_back(8'($urandom_range(0, 255)));
		end
		if (corrupt) begin
			bad_type = 2'($urandom_range(1, 2));
			msg_bytes.push_back({bad_type, 6'($urandom)});
		end else if ($urandom_range(0, 2) == 0) begin
			msg_bytes.push_back({2'b11, 6'($urandom)});
			msg_bytes.push_back(8'($urandom_range(0, 255)));
		end else begin
			msg_bytes.push_back(8'h00);
		end
	endtask

	function automatic int clip3(input logic [15:0] n);
		return (n > 3) ? 3 : int'(n);
	endfunction

	// Header plus up to three records per section. With large counts the
	// message simply runs out before the parser's counts do.
	task automatic build_message(input logic [15:0] qd, an, ns, ar, input int bad_name);
		int   n_q;
		int   n_all;
		int   rdlen;
		msg_bytes.delete();
		push_word(16'($urandom));
		push_word(16'($urandom));
		push_word(qd);
		push_word(an);
		push_word(ns);
		push_word(ar);
		n_q = clip3(qd);
		n_all = n_q + clip3(an) + clip3(ns) + clip3(ar);
		for (int i = 0; i < n_all; i++) begin
			push_name(i == bad_name);
			if (i == bad_name) return;
			push_word(16'($urandom));
			push_word(16'($urandom));
			if (i >= n_q) begin
				push_word(16'($urandom));
				push_word(16'($urandom));
				rdlen = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 40) : $urandom_range(0, 5);
				push_word(16'(rdlen));
				repeat (rdlen) msg_bytes.push_back(8'($urandom_range(0, 255)));
			end
		end
	endtask

	initial begin
		int          pick;
		int          n_noise;
		bit          held;
		bit          paused;
		logic [15:0] qd, an, ns, ar;

		held = 1'b0;
		paused = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// --- directed beats ---
		gap_odds = $urandom_range(0, 3);
		// stray byte before any start
		send_byte(8'hFF, 1'b0);
		// id sent, then the message abandoned by a fresh start
		msg_bytes = '{8'h00, 8'h01};
		send_message(1'b1);
		// empty message: id all ones, every count zero, arcount closes it
		msg_bytes = '{8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00,
			8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
		send_message(1'b1);
		send_byte(8'hA5, 1'b0);
		// two additionals: first named by the highest pointer, zero rdlength;
		// second name opens with a reserved label type
		msg_bytes = '{8'h80, 8'h00, 8'h7F, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00,
			8'h00, 8'h00, 8'h00, 8'h02,
			8'hFF, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'h01,
			8'h80, 8'h00, 8'h00, 8'h01, 8'h00, 8'h00,
			8'h40};
		send_message(1'b1);
		send_byte(8'h00, 1'b0);
		drain();

		// --- random messages ---
		while (bytes_fed < ITEM_TARGET) begin
			gap_odds = $urandom_range(0, 3);
			if (!held && bytes_fed > 600) begin
				long_hold_req = 1'b1;
				held = 1'b1;
			end
			if (!paused && bytes_fed > 1100) begin
				drain();
				paused = 1'b1;
			end
			if (bytes_fed > 1500) no_idle = 1'b1;

			qd = 16'($urandom_range(0, 1));
			an = 16'($urandom_range(0, 2));
			ns = 16'($urandom_range(0, 1));
			ar = 16'($urandom_range(0, 1));
			pick = $urandom_range(0, 99);
			if (pick < 70) begin
				build_message(qd, an, ns, ar, -1);
				send_message(1'b1);
			end else if (pick < 80) begin
				// cut short; the next start lands mid-message
				if ($urandom_range(0, 1) == 0) begin
					qd = 16'($urandom);
					an = 16'($urandom);
					ns = 16'($urandom);
					ar = 16'($urandom);
				end
				build_message(qd, an, ns, ar, -1);
				msg_bytes = msg_bytes[0:$urandom_range(0, msg_bytes.size() - 2)];
				send_message(1'b1);
			end else if (pick < 88) begin
				ar = 16'($urandom_range(1, 2));
				build_message(qd, an, ns, ar,
					$urandom_range(0, clip3(qd) + clip3(an) + clip3(ns) + clip3(ar) - 1));
				send_message(1'b1);
				send_junk($urandom_range(0, 4));
			end else if (pick < 94) begin
				build_message(qd, an, ns, ar, -1);
				send_message(1'b1);
				send_junk($urandom_range(1, 4));
			end else begin
				// raw noise with the odd restart
				n_noise = $urandom_range(1, 20);
				for (int i = 0; i < n_noise; i++) begin
					send_byte(8'($urandom_range(0, 255)), i == 0 || $urandom_range(0, 15) == 0);
					bytes_fed++;
				end
			end
		end

		drain();
		repeat (20) @(posedge clk);
		if (error_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

### dns_response_parser.f
hw/rtl/dnsp_pkg.sv
hw/rtl/dnsp_parser.sv
hw/rtl/dnsp_queue.sv
hw/rtl/dns_response_parser.sv
sim/dns_event_checker.sv
sim/testbench.sv
